### rtl/glyph_to_framebuffer_blitter_unit_defines.svh
// assertion helpers used by the blitter rtl
`ifndef GLYPH_TO_FRAMEBUFFER_BLITTER_UNIT_DEFINES_SVH
`define GLYPH_TO_FRAMEBUFFER_BLITTER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GTFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GTFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gtfb_pkg.sv
package gtfb_pkg;

  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_COLS  = 8;
  localparam int GLYPH_COUNT = 256;

  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ROW_W       = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int COL_W       = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;

  // gray = (30r + 59g + 11b) / 100 via reciprocal multiply
  localparam int GRAY_R     = 30;
  localparam int GRAY_G     = 59;
  localparam int GRAY_B     = 11;
  localparam int GRAY_DIV   = 100;
  localparam int GRAY_SUM_W = 15;
  localparam int GRAY_SHIFT = 22;
  localparam int GRAY_K_W   = 16;
  localparam int GRAY_K     = ((1 << GRAY_SHIFT) + GRAY_DIV - 1) / GRAY_DIV;
  localparam int GRAY_P_W   = GRAY_SUM_W + GRAY_K_W;

  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_16 = 6'd16;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;

  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LINE_PITCH    = 3'd2;
  localparam logic [2:0] REG_BPP           = 3'd3;
  localparam logic [2:0] REG_FRAME_BASE    = 3'd4;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [1:0] {
    FMT_8,
    FMT_16,
    FMT_24,
    FMT_32
  } fmt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BASE,
    S_XOFF,
    S_COLR,
    S_PIX,
    S_ROW
  } state_t;

  function automatic logic [2:0] fmt_bytes(input fmt_t fmt);
    logic [2:0] n;
    case (fmt)
      FMT_8:   n = 3'd1;
      FMT_16:  n = 3'd2;
      FMT_24:  n = 3'd3;
      FMT_32:  n = 3'd4;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

### rtl/gtfb_pix.sv
module gtfb_pix (
  input  logic                clk,
  input  logic [31:0]         color,
  input  gtfb_pkg::fmt_t      fmt,
  output logic [31:0]         pix
);

  logic [7:0] r, g, b;
  logic [gtfb_pkg::GRAY_SUM_W-1:0] sum_r;
  logic [31:0] direct_r;
  gtfb_pkg::fmt_t fmt_r;
  logic [gtfb_pkg::GRAY_P_W-1:0] prod;
  logic [31:0] pix_r;

  assign r = color[23:16];
  assign g = color[15:8];
  assign b = color[7:0];

  // stage 1: weighted sum for gray, final value for the other depths
  always_ff @(posedge clk) begin
    sum_r <= gtfb_pkg::GRAY_SUM_W'(r) * gtfb_pkg::GRAY_SUM_W'(gtfb_pkg::GRAY_R)
           + gtfb_pkg::GRAY_SUM_W'(g) * gtfb_pkg::GRAY_SUM_W'(gtfb_pkg::GRAY_G)
           + gtfb_pkg::GRAY_SUM_W'(b) * gtfb_pkg::GRAY_SUM_W'(gtfb_pkg::GRAY_B);
    fmt_r <= fmt;
    case (fmt)
      gtfb_pkg::FMT_32: direct_r <= color;
      gtfb_pkg::FMT_24: direct_r <= {8'h00, color[23:0]};
      gtfb_pkg::FMT_16: direct_r <= {16'h0000, r[7:3], g[7:2], b[7:3]};
      default:          direct_r <= 32'h0;
    endcase
  end

  assign prod = gtfb_pkg::GRAY_P_W'(sum_r) * gtfb_pkg::GRAY_P_W'(gtfb_pkg::GRAY_K);

  // stage 2: divide by 100 through the reciprocal for gray, else pass the direct value
  always_ff @(posedge clk) begin
    if (fmt_r == gtfb_pkg::FMT_8) begin
      pix_r <= {24'h0, prod[gtfb_pkg::GRAY_SHIFT +: 8]};
    end else begin
      pix_r <= direct_r;
    end
  end

  assign pix = pix_r;

endmodule

### rtl/glyph_to_framebuffer_blitter_unit.sv
// 8x8 font blitter: load requests fill a 256 x 8-row font store, draw requests
// expand one character cell into 64 framebuffer pixel writes.
// input channel: in_valid / in_stall, one request per accept; in_req_type
//   selects a font row load (no output) or a character draw
// output channel: out_valid / out_stall, one pixel write per accept, row by
//   row, leftmost pixel first; out_last_pixel marks the 64th write
// config: cfg_we writes register cfg_index with cfg_wdata; the user writes
//   only while idle, which the block itself does not enforce
// a draw runs states S_MUL, S_BASE, S_XOFF, S_COLR (pitch multiply, base and
//   x offset adds, color conversion), then 8 rows of 8 writes with one row
//   step in between; one shared 32-bit address adder walks columns and rows
// a draw whose start is off screen or whose depth is unsupported is dropped
// in_stall is high while a draw is in progress; an output stall only holds
//   the current write and pauses the walk
// reset restores the default registers and empties the output; font store
//   contents are undefined until loaded
`include "glyph_to_framebuffer_blitter_unit_defines.svh"

module glyph_to_framebuffer_blitter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_char_code,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [31:0]        in_fore_color,
  input  logic [31:0]        in_back_color,
  input  logic [10:0]        in_font_index,
  input  logic [7:0]         in_font_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_write_address,
  output logic [31:0]        out_write_data,
  output logic [2:0]         out_write_bytes,
  output logic               out_last_pixel,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int AW = gtfb_pkg::STORE_AW;
  localparam int RW = gtfb_pkg::ROW_W;
  localparam int CW = gtfb_pkg::COL_W;

  gtfb_pkg::state_t state_r, state_nxt;

  logic [12:0] screen_width_r, screen_height_r;
  logic [15:0] line_pitch_r;
  logic [5:0]  bpp_r;
  logic [31:0] frame_base_r;

  logic [7:0]  code_r;
  logic [12:0] py_r;
  logic [14:0] xoff_r;
  logic [31:0] fg_r, bg_r, fg_pix_r, bg_pix_r;
  gtfb_pkg::fmt_t fmt_r;
  logic [28:0] prod_r;
  logic [31:0] rowaddr_r, addr_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic [7:0]  font_mem [gtfb_pkg::STORE_DEPTH];
  logic [7:0]  rd_r;
  logic [AW-1:0] rd_addr;

  logic        out_valid_r, out_last_r;
  logic [31:0] out_addr_r, out_data_r;
  logic [2:0]  out_bytes_r;

  logic in_accept, load_we, draw_ok, accept_draw, out_free, emit;
  logic col_last, row_last;
  logic x_ok, y_ok, bpp_ok, code_ok;
  gtfb_pkg::fmt_t in_fmt;
  logic [14:0] in_xoff;
  logic [2:0]  bpb;
  logic [31:0] add_a, add_b, add_sum;
  logic [31:0] conv_color, conv_pix;
  logic [CW-1:0] bit_idx;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != gtfb_pkg::S_IDLE);
  assign load_we   = in_accept && (in_req_type == gtfb_pkg::REQ_LOAD)
                     && (32'(in_font_index) < gtfb_pkg::STORE_DEPTH);

  // start position and depth checks for a draw request
  assign x_ok    = !in_pos_x[15] && ($unsigned(in_pos_x) < {3'b000, screen_width_r});
  assign y_ok    = !in_pos_y[15] && ($unsigned(in_pos_y) < {3'b000, screen_height_r});
  assign code_ok = 32'(in_char_code) < gtfb_pkg::GLYPH_COUNT;

  always_comb begin
    bpp_ok = 1'b1;
    in_fmt = gtfb_pkg::FMT_32;
    case (bpp_r)
      gtfb_pkg::BPP_8:  in_fmt = gtfb_pkg::FMT_8;
      gtfb_pkg::BPP_16: in_fmt = gtfb_pkg::FMT_16;
      gtfb_pkg::BPP_24: in_fmt = gtfb_pkg::FMT_24;
      gtfb_pkg::BPP_32: in_fmt = gtfb_pkg::FMT_32;
      default:          bpp_ok = 1'b0;
    endcase
  end

  // x offset in bytes: px * bytes per pixel, px below 8192
  always_comb begin
    case (in_fmt)
      gtfb_pkg::FMT_8:  in_xoff = 15'(in_pos_x[12:0]);
      gtfb_pkg::FMT_16: in_xoff = {1'b0, in_pos_x[12:0], 1'b0};
      gtfb_pkg::FMT_24: in_xoff = {1'b0, in_pos_x[12:0], 1'b0} + 15'(in_pos_x[12:0]);
      default:          in_xoff = {in_pos_x[12:0], 2'b00};
    endcase
  end

  assign draw_ok     = x_ok && y_ok && bpp_ok && code_ok;
  assign accept_draw = in_accept && (in_req_type == gtfb_pkg::REQ_DRAW) && draw_ok;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (state_r == gtfb_pkg::S_PIX) && out_free;
  assign col_last = (col_r == CW'(gtfb_pkg::GLYPH_COLS - 1));
  assign row_last = (row_r == RW'(gtfb_pkg::GLYPH_ROWS - 1));
  assign bpb      = gtfb_pkg::fmt_bytes(fmt_r);
  assign bit_idx  = CW'(gtfb_pkg::GLYPH_COLS - 1) - col_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gtfb_pkg::S_IDLE: if (accept_draw) state_nxt = gtfb_pkg::S_MUL;
      gtfb_pkg::S_MUL:  state_nxt = gtfb_pkg::S_BASE;
      gtfb_pkg::S_BASE: state_nxt = gtfb_pkg::S_XOFF;
      gtfb_pkg::S_XOFF: state_nxt = gtfb_pkg::S_COLR;
      gtfb_pkg::S_COLR: state_nxt = gtfb_pkg::S_PIX;
      gtfb_pkg::S_PIX: begin
        if (emit && col_last) begin
          state_nxt = row_last ? gtfb_pkg::S_IDLE : gtfb_pkg::S_ROW;
        end
      end
      gtfb_pkg::S_ROW:  state_nxt = gtfb_pkg::S_PIX;
      default:          state_nxt = gtfb_pkg::S_IDLE;
    endcase
  end

  // shared adder operands and walk counters
  always_comb begin
    add_a   = addr_r;
    add_b   = 32'(bpb);
    row_nxt = row_r;
    col_nxt = col_r;
    case (state_r)
      gtfb_pkg::S_IDLE: begin
        if (accept_draw) begin
          row_nxt = '0;
          col_nxt = '0;
        end
      end
      gtfb_pkg::S_BASE: begin
        add_a = frame_base_r;
        add_b = 32'(prod_r);
      end
      gtfb_pkg::S_XOFF: begin
        add_a = rowaddr_r;
        add_b = 32'(xoff_r);
      end
      gtfb_pkg::S_PIX: begin
        if (emit) col_nxt = col_last ? '0 : col_r + CW'(1);
      end
      gtfb_pkg::S_ROW: begin
        add_a   = rowaddr_r;
        add_b   = 32'(line_pitch_r);
        row_nxt = row_r + RW'(1);
      end
      default: begin
        add_a = addr_r;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // color conversion: foreground enters in S_MUL, background in S_BASE
  assign conv_color = (state_r == gtfb_pkg::S_MUL) ? fg_r : bg_r;

  gtfb_pix u_pix (
    .clk   (clk),
    .color (conv_color),
    .fmt   (fmt_r),
    .pix   (conv_pix)
  );

  // font store, read at row_nxt so that the registered rd_r holds the row of row_r
  assign rd_addr = AW'(code_r * AW'(gtfb_pkg::GLYPH_ROWS)) + AW'(row_nxt);

  always_ff @(posedge clk) begin
    if (load_we) font_mem[in_font_index[AW-1:0]] <= in_font_row;
    rd_r <= font_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= gtfb_pkg::S_IDLE;
      out_valid_r     <= 1'b0;
      row_r           <= '0;
      col_r           <= '0;
      screen_width_r  <= 13'd640;
      screen_height_r <= 13'd480;
      line_pitch_r    <= 16'd2560;
      bpp_r           <= 6'd32;
      frame_base_r    <= 32'h0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          gtfb_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[12:0];
          gtfb_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[12:0];
          gtfb_pkg::REG_LINE_PITCH:    line_pitch_r    <= cfg_wdata[15:0];
          gtfb_pkg::REG_BPP:           bpp_r           <= cfg_wdata[5:0];
          gtfb_pkg::REG_FRAME_BASE:    frame_base_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // draw datapath
  always_ff @(posedge clk) begin
    if (accept_draw) begin
      code_r <= in_char_code;
      py_r   <= in_pos_y[12:0];
      xoff_r <= in_xoff;
      fg_r   <= in_fore_color;
      bg_r   <= in_back_color;
      fmt_r  <= in_fmt;
    end
    case (state_r)
      gtfb_pkg::S_MUL:  prod_r <= 29'(py_r) * 29'(line_pitch_r);
      gtfb_pkg::S_BASE: rowaddr_r <= add_sum;
      gtfb_pkg::S_XOFF: begin
        rowaddr_r <= add_sum;
        addr_r    <= add_sum;
        fg_pix_r  <= conv_pix;
      end
      gtfb_pkg::S_COLR: bg_pix_r <= conv_pix;
      gtfb_pkg::S_PIX: begin
        if (emit) addr_r <= add_sum;
      end
      gtfb_pkg::S_ROW: begin
        rowaddr_r <= add_sum;
        addr_r    <= add_sum;
      end
      default: ;
    endcase
    if (emit) begin
      out_addr_r  <= addr_r;
      out_data_r  <= rd_r[bit_idx] ? fg_pix_r : bg_pix_r;
      out_bytes_r <= bpb;
      out_last_r  <= col_last && row_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_write_bytes   = out_bytes_r;
  assign out_last_pixel    = out_last_r;

  `GTFB_ASSERT_NXT(a_row_step, clk, rst_n, state_r == gtfb_pkg::S_ROW,
    state_r == gtfb_pkg::S_PIX && col_r == '0, "row step must resume at column zero")
  `GTFB_ASSERT_IMP(a_setup_origin, clk, rst_n, state_r == gtfb_pkg::S_COLR,
    row_r == '0 && col_r == '0, "draw setup must start at the top left pixel")
  `GTFB_ASSERT_NXT(a_emit_valid, clk, rst_n, emit,
    out_valid_r, "emitted pixel write lost")
  `GTFB_ASSERT_NXT(a_last_done, clk, rst_n, emit && col_last && row_last,
    state_r == gtfb_pkg::S_IDLE && out_last_r, "final write must end the draw")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS  = 31;

  localparam logic [7:0] GLYPH_ART [16] = '{
    8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
    8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42, 8'hFF
  };

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] fore_color;
    logic [31:0] back_color;
    logic [10:0] font_index;
    logic [7:0]  font_row;
  } glyph_req_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } fb_write_t;

  // how a request's pixel writes are known: from the predictor, typed as none,
  // or typed for the first write with the rest predicted
  typedef enum logic [1:0] {
    GOLDEN_MODEL,
    GOLDEN_EMPTY,
    GOLDEN_FIRST
  } golden_t;

  typedef struct {
    bit         is_cfg;
    logic [2:0] reg_idx;
    logic [31:0] reg_val;
    glyph_req_t req;
    golden_t    golden;
    fb_write_t  first;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_write_address;
  logic [31:0] out_write_data;
  logic [2:0]  out_write_bytes;
  logic        out_last_pixel;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = gtfb_pkg::REG_SCREEN_WIDTH;
  logic [31:0] cfg_wdata = '0;

  glyph_req_t cur_req = '0;
  golden_t    cur_golden = GOLDEN_MODEL;
  fb_write_t  cur_first = '0;

  logic               in_req_type;
  logic [7:0]         in_char_code;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic [31:0]        in_fore_color;
  logic [31:0]        in_back_color;
  logic [10:0]        in_font_index;
  logic [7:0]         in_font_row;

  assign in_req_type   = cur_req.req_type;
  assign in_char_code  = cur_req.char_code;
  assign in_pos_x      = cur_req.pos_x;
  assign in_pos_y      = cur_req.pos_y;
  assign in_fore_color = cur_req.fore_color;
  assign in_back_color = cur_req.back_color;
  assign in_font_index = cur_req.font_index;
  assign in_font_row   = cur_req.font_row;

  // register copies and font contents as the block should see them
  logic [12:0] sh_width;
  logic [12:0] sh_height;
  logic [15:0] sh_pitch;
  logic [5:0]  sh_bpp;
  logic [31:0] sh_base;
  logic [7:0]  font_copy [0:gtfb_pkg::STORE_DEPTH-1];

  fb_write_t expected_writes[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        idling_on = 1'b1;

  // generator side bookkeeping: only fully loaded glyphs get drawn
  logic [7:0] rows_loaded [0:gtfb_pkg::GLYPH_COUNT-1];
  bit         code_listed [0:gtfb_pkg::GLYPH_COUNT-1];
  logic [7:0] drawable_codes[$];

  glyph_to_framebuffer_blitter_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_char_code      (in_char_code),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_fore_color     (in_fore_color),
    .in_back_color     (in_back_color),
    .in_font_index     (in_font_index),
    .in_font_row       (in_font_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_bytes   (out_write_bytes),
    .out_last_pixel    (out_last_pixel),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= idling_on && ($urandom_range(0, 99) < 26);
  end

  function automatic logic [31:0] pixel_bits(input logic [31:0] color, input logic [5:0] bpp);
    int unsigned gray;
    logic [31:0] px;
    gray = color[23:16] * 30 + color[15:8] * 59 + color[7:0] * 11;
    case (bpp)
      gtfb_pkg::BPP_32: px = color;
      gtfb_pkg::BPP_24: px = {8'h00, color[23:0]};
      gtfb_pkg::BPP_16: px = {16'h0000, color[23:19], color[15:10], color[7:3]};
      default:          px = {24'h000000, 8'(gray / 100)};
    endcase
    return px;
  endfunction

  // font row loads update the store copy; draws expand into pixel writes
  task automatic predict_glyph_writes(input glyph_req_t r);
    int x;
    int y;
    logic [31:0] bpb;
    logic [31:0] line_addr;
    logic [7:0]  bits;
    fb_write_t   w;
    if (r.req_type == gtfb_pkg::REQ_LOAD) begin
      font_copy[r.font_index] = r.font_row;
      return;
    end
    x = $signed(r.pos_x);
    y = $signed(r.pos_y);
    if (x < 0 || y < 0 || x >= int'(sh_width) || y >= int'(sh_height))
      return;
    if (sh_bpp != gtfb_pkg::BPP_8 && sh_bpp != gtfb_pkg::BPP_16 &&
        sh_bpp != gtfb_pkg::BPP_24 && sh_bpp != gtfb_pkg::BPP_32)
      return;
    bpb = 32'(sh_bpp[5:3]);
    for (int row = 0; row < gtfb_pkg::GLYPH_ROWS; row++) begin
      bits = font_copy[{r.char_code, 3'(row)}];
      line_addr = sh_base + (32'(y) + 32'(row)) * 32'(sh_pitch);
      for (int col = 0; col < gtfb_pkg::GLYPH_COLS; col++) begin
        w.addr   = line_addr + (32'(x) + 32'(col)) * bpb;
        w.data   = pixel_bits(bits[gtfb_pkg::GLYPH_COLS-1-col] ? r.fore_color : r.back_color,
                              sh_bpp);
        w.nbytes = sh_bpp[5:3];
        w.last   = (row == gtfb_pkg::GLYPH_ROWS - 1) && (col == gtfb_pkg::GLYPH_COLS - 1);
        expected_writes.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin : scoreboard
    fb_write_t want;
    int base;
    if (!rst_n) begin
      sh_width  = 13'd640;
      sh_height = 13'd480;
      sh_pitch  = 16'd2560;
      sh_bpp    = gtfb_pkg::BPP_32;
      sh_base   = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gtfb_pkg::REG_SCREEN_WIDTH:  sh_width  = cfg_wdata[12:0];
          gtfb_pkg::REG_SCREEN_HEIGHT: sh_height = cfg_wdata[12:0];
          gtfb_pkg::REG_LINE_PITCH:    sh_pitch  = cfg_wdata[15:0];
          gtfb_pkg::REG_BPP:           sh_bpp    = cfg_wdata[5:0];
          gtfb_pkg::REG_FRAME_BASE:    sh_base   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_writes.size() == 0) begin
          $error("pixel write with none pending: address %h", out_write_address);
          mismatch_count++;
        end else begin
          want = expected_writes.pop_front();
          if (out_write_address !== want.addr) begin
            $error("write_address expected %h actual %h", want.addr, out_write_address);
            mismatch_count++;
          end
          if (out_write_data !== want.data) begin
            $error("write_data expected %h actual %h", want.data, out_write_data);
            mismatch_count++;
          end
          if (out_write_bytes !== want.nbytes) begin
            $error("write_bytes expected %0d actual %0d", want.nbytes, out_write_bytes);
            mismatch_count++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel expected %0d actual %0d", want.last, out_last_pixel);
            mismatch_count++;
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        base = expected_writes.size();
        if (cur_golden != GOLDEN_EMPTY)
          predict_glyph_writes(cur_req);
        if (cur_golden == GOLDEN_FIRST && expected_writes.size() > base)
          expected_writes[base] = cur_first;
      end
    end
  end

  function automatic glyph_req_t load_req(input logic [10:0] idx, input logic [7:0] bits);
    glyph_req_t r;
    r = '0;
    r.req_type   = gtfb_pkg::REQ_LOAD;
    r.font_index = idx;
    r.font_row   = bits;
    return r;
  endfunction

  function automatic glyph_req_t draw_req(input logic [7:0] code, input int x, input int y,
                                          input logic [31:0] fg, input logic [31:0] bg);
    glyph_req_t r;
    r = '0;
    r.req_type   = gtfb_pkg::REQ_DRAW;
    r.char_code  = code;
    r.pos_x      = 16'(x);
    r.pos_y      = 16'(y);
    r.fore_color = fg;
    r.back_color = bg;
    return r;
  endfunction

  function automatic stim_row_t req_row(input glyph_req_t r, input golden_t g,
                                        input fb_write_t first);
    stim_row_t s;
    s.is_cfg  = 1'b0;
    s.reg_idx = gtfb_pkg::REG_SCREEN_WIDTH;
    s.reg_val = '0;
    s.req     = r;
    s.golden  = g;
    s.first   = first;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] val);
    stim_row_t s;
    s = req_row('0, GOLDEN_MODEL, '0);
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic fb_write_t pix(input logic [31:0] addr, input logic [31:0] data,
                                    input logic [2:0] nbytes);
    fb_write_t w;
    w.addr   = addr;
    w.data   = data;
    w.nbytes = nbytes;
    w.last   = 1'b0;
    return w;
  endfunction

  task automatic send_request(input glyph_req_t r, input golden_t g, input fb_write_t first);
    logic [7:0] code;
    if (r.req_type == gtfb_pkg::REQ_LOAD) begin
      code = r.font_index[10:3];
      rows_loaded[code][r.font_index[2:0]] = 1'b1;
      if (&rows_loaded[code] && !code_listed[code]) begin
        code_listed[code] = 1'b1;
        drawable_codes.push_back(code);
      end
    end
    @(negedge clk);
    while (idling_on && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cur_req    <= r;
    cur_golden <= g;
    cur_first  <= first;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
  endtask

  // stop sending and let every pending write and any dropped draw finish
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_writes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n_items, input bit pause_midway);
    int sent;
    int pick;
    int x;
    int y;
    int w;
    int h;
    bit paused;
    logic [7:0] code;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (pause_midway && !paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12 || drawable_codes.size() == 0) begin
        // whole glyph, rows in order
        code = 8'($urandom_range(0, gtfb_pkg::GLYPH_COUNT - 1));
        for (int row = 0; row < gtfb_pkg::GLYPH_ROWS; row++)
          send_request(load_req({code, 3'(row)}, 8'($urandom)), GOLDEN_MODEL, '0);
        sent += gtfb_pkg::GLYPH_ROWS;
      end else if (pick < 30) begin
        send_request(load_req(11'($urandom), 8'($urandom)), GOLDEN_MODEL, '0);
        sent++;
      end else begin
        code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
        w = sh_width;
        h = sh_height;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          x = $urandom_range(0, w - 1);
          y = $urandom_range(0, h - 1);
        end else if (pick == 7) begin
          x = w - 1;
          y = h - 1;
        end else if (pick == 8) begin
          x = $signed(16'($urandom));
          y = $signed(16'($urandom));
        end else if ($urandom_range(0, 1) == 0) begin
          x = w;
          y = $urandom_range(0, h - 1);
        end else begin
          x = $urandom_range(0, w - 1);
          y = h;
        end
        send_request(draw_req(code, x, y, $urandom, $urandom), GOLDEN_MODEL, '0);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    stim_row_t   stim_table[$];
    int          w;
    int          h;
    logic [15:0] pitch;
    logic [5:0]  bpp;
    logic [31:0] base;
    for (int c = 0; c < gtfb_pkg::GLYPH_COUNT; c++) begin
      rows_loaded[c] = '0;
      code_listed[c] = 1'b0;
    end

    for (int i = 0; i < 16; i++)
      stim_table.push_back(req_row(load_req(i < 8 ? 11'(i) : 11'(2032 + i), GLYPH_ART[i]),
                                   GOLDEN_MODEL, '0));
    // default registers after reset: 32 bpp, pitch 2560, base 0
    stim_table.push_back(req_row(draw_req(8'd0, 0, 0, 32'hFFFF_FFFF, 32'h0),
                                 GOLDEN_FIRST, pix(32'h0, 32'hFFFF_FFFF, 3'd4)));
    // bottom right corner, cell runs past both edges
    stim_table.push_back(req_row(draw_req(8'd255, 639, 479, 32'h1234_5678, 32'h9ABC_DEF0),
                                 GOLDEN_MODEL, '0));
    stim_table.push_back(req_row(draw_req(8'd0, -1, 0, 32'h1, 32'h2), GOLDEN_EMPTY, '0));
    stim_table.push_back(req_row(draw_req(8'd0, 640, 0, 32'h1, 32'h2), GOLDEN_EMPTY, '0));
    stim_table.push_back(req_row(draw_req(8'd255, 0, 480, 32'h1, 32'h2), GOLDEN_EMPTY, '0));
    stim_table.push_back(req_row(draw_req(8'd255, 32767, -32768, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF), GOLDEN_EMPTY, '0));
    stim_table.push_back(req_row(draw_req(8'd0, -32768, 32767, 32'h0, 32'h0),
                                 GOLDEN_EMPTY, '0));
    // unsupported depth drops the draw
    stim_table.push_back(cfg_row(gtfb_pkg::REG_BPP, 32'd0));
    stim_table.push_back(req_row(draw_req(8'd0, 0, 0, 32'h1, 32'h2), GOLDEN_EMPTY, '0));
    // white at 8 bpp is gray 0xff
    stim_table.push_back(cfg_row(gtfb_pkg::REG_BPP, 32'(gtfb_pkg::BPP_8)));
    stim_table.push_back(req_row(draw_req(8'd0, 0, 0, 32'hFFFF_FFFF, 32'h0),
                                 GOLDEN_FIRST, pix(32'h0, 32'h0000_00FF, 3'd1)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        wait_drained();
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
      end else begin
        send_request(stim_table[i].req, stim_table[i].golden, stim_table[i].first);
      end
    end

    for (int p = 0; p < 10; p++) begin
      if (p == 0) begin
        w = 4096;
        h = 4096;
        pitch = 16'hFFFF;
        bpp = gtfb_pkg::BPP_32;
        base = 32'hFFFF_FFFF;
      end else if (p == 1) begin
        w = 1;
        h = 1;
        pitch = 16'h0;
        bpp = gtfb_pkg::BPP_24;
        base = 32'h0;
      end else begin
        w = $urandom_range(1, 4096);
        h = $urandom_range(1, 4096);
        pitch = 16'($urandom);
        base = $urandom;
        if (p == 2)
          bpp = gtfb_pkg::BPP_16;
        else if (p == 3)
          bpp = gtfb_pkg::BPP_8;
        else if (p == 4) begin
          do
            bpp = 6'($urandom_range(0, 32));
          while (bpp == gtfb_pkg::BPP_8 || bpp == gtfb_pkg::BPP_16 ||
                 bpp == gtfb_pkg::BPP_24 || bpp == gtfb_pkg::BPP_32);
        end else begin
          case ($urandom_range(0, 3))
            0:       bpp = gtfb_pkg::BPP_8;
            1:       bpp = gtfb_pkg::BPP_16;
            2:       bpp = gtfb_pkg::BPP_24;
            default: bpp = gtfb_pkg::BPP_32;
          endcase
        end
      end
      wait_drained();
      write_reg(gtfb_pkg::REG_SCREEN_WIDTH, 32'(w));
      write_reg(gtfb_pkg::REG_SCREEN_HEIGHT, 32'(h));
      write_reg(gtfb_pkg::REG_LINE_PITCH, 32'(pitch));
      write_reg(gtfb_pkg::REG_BPP, 32'(bpp));
      write_reg(gtfb_pkg::REG_FRAME_BASE, base);
      // one phase runs with no gaps on either side
      idling_on = (p != 5);
      run_phase(PHASE_ITEMS, p == 6);
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/gtfb_pkg.sv
rtl/gtfb_pix.sv
rtl/glyph_to_framebuffer_blitter_unit.sv
dv/testbench.sv
